>>> hw/rtl/slsfp_pkg.sv
// Shared types and constants of the sync, length and checksum frame parser.
package slsfp_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'h5A;
    localparam logic [7:0] SYNC_SECOND = 8'hA5;
    localparam logic [7:0] FIXED_LEN   = 8'd6;
    localparam logic [5:0] CMD_POS     = 6'd3;
    localparam logic [5:0] EP_POS      = 6'd4;
    localparam logic [5:0] PAYLOAD_POS = 6'd5;

    typedef enum logic [2:0] {
        ST_HUNT1,
        ST_HUNT2,
        ST_LEN,
        ST_BODY,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic [5:0] payload_index;
        logic [5:0] payload_count;
        logic [7:0] command_byte;
        logic [7:0] endpoint_byte;
        logic       last_of_frame;
    } t_result;

    typedef struct packed {
        logic wr;
        logic pos_clr;
        logic sum_load;
        logic sum_add;
        logic len_load;
        logic emit_start;
        logic rd_en;
    } t_cmd;

    typedef struct packed {
        logic is_sync1;
        logic is_sync2;
        logic len_ok;
        logic body_more;
        logic sum_match;
        logic rd_last;
        logic out_valid;
    } t_sts;

endpackage

>>> hw/rtl/slsfp_in_if.sv
// Received byte channel.
interface slsfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> hw/rtl/slsfp_out_if.sv
// Payload result channel.
interface slsfp_out_if;
    logic                  valid;
    logic                  ready;
    slsfp_pkg::t_result    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/slsfp_ram.sv
// Generic single write port RAM with registered read.
module slsfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/slsfp_ctrl.sv
// Parser state machine: sync hunt, length, body, checksum and payload run.
module slsfp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    input  slsfp_pkg::t_sts   i_sts,
    output slsfp_pkg::t_cmd   o_cmd
);

    slsfp_pkg::t_state r_state;
    slsfp_pkg::t_state n_state;
    logic              acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= slsfp_pkg::ST_HUNT1;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = (r_state != slsfp_pkg::ST_EMIT);
        acc        = i_in_valid && o_in_ready;
        case (r_state)
            slsfp_pkg::ST_HUNT1: begin
                if (acc && i_sts.is_sync1) begin
                    o_cmd.wr       = 1'b1;
                    o_cmd.sum_load = 1'b1;
                    n_state        = slsfp_pkg::ST_HUNT2;
                end
            end
            slsfp_pkg::ST_HUNT2: begin
                if (acc) begin
                    if (i_sts.is_sync2) begin
                        o_cmd.wr      = 1'b1;
                        o_cmd.sum_add = 1'b1;
                        n_state       = slsfp_pkg::ST_LEN;
                    end else begin
                        o_cmd.pos_clr = 1'b1;
                        n_state       = slsfp_pkg::ST_HUNT1;
                    end
                end
            end
            slsfp_pkg::ST_LEN: begin
                if (acc) begin
                    if (i_sts.len_ok) begin
                        o_cmd.wr       = 1'b1;
                        o_cmd.sum_add  = 1'b1;
                        o_cmd.len_load = 1'b1;
                        n_state        = slsfp_pkg::ST_BODY;
                    end else begin
                        o_cmd.pos_clr = 1'b1;
                        n_state       = slsfp_pkg::ST_HUNT1;
                    end
                end
            end
            slsfp_pkg::ST_BODY: begin
                if (acc) begin
                    if (i_sts.body_more) begin
                        o_cmd.wr      = 1'b1;
                        o_cmd.sum_add = 1'b1;
                    end else begin
                        o_cmd.pos_clr = 1'b1;
                        if (i_sts.sum_match) begin
                            o_cmd.emit_start = 1'b1;
                            n_state          = slsfp_pkg::ST_EMIT;
                        end else begin
                            n_state = slsfp_pkg::ST_HUNT1;
                        end
                    end
                end
            end
            slsfp_pkg::ST_EMIT: begin
                o_cmd.rd_en = !i_sts.out_valid || i_out_ready;
                if (o_cmd.rd_en && i_sts.rd_last) begin
                    n_state = slsfp_pkg::ST_HUNT1;
                end
            end
            default: begin
                n_state = slsfp_pkg::ST_HUNT1;
            end
        endcase
    end

endmodule

>>> hw/rtl/slsfp_dp.sv
// Parser datapath: frame store, position, length, sum and output register.
module slsfp_dp #(
    parameter int MAX_FRAME = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [7:0]         i_rx_byte,
    input  slsfp_pkg::t_cmd    i_cmd,
    output slsfp_pkg::t_sts    o_sts,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output slsfp_pkg::t_result o_res
);

    localparam int AW = $clog2(MAX_FRAME);

    logic [5:0] r_wp;
    logic [5:0] n_wp;
    logic [5:0] r_len;
    logic [7:0] r_sum;
    logic [7:0] r_cmd_byte;
    logic [7:0] r_ep_byte;
    logic [5:0] r_k;
    logic [5:0] r_cnt;
    logic       r_out_vld;
    logic       n_out_vld;
    logic [5:0] r_out_idx;
    logic       r_out_last;
    logic [5:0] r_out_cnt;
    logic [7:0] r_out_cmd;
    logic [7:0] r_out_ep;
    logic [5:0] rd_addr;
    logic [7:0] rd_data;

    assign rd_addr = slsfp_pkg::PAYLOAD_POS + r_k;

    slsfp_ram #(
        .WIDTH (8),
        .DEPTH (MAX_FRAME)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr),
        .i_waddr (r_wp[AW-1:0]),
        .i_wdata (i_rx_byte),
        .i_re    (i_cmd.rd_en),
        .i_raddr (rd_addr[AW-1:0]),
        .o_rdata (rd_data)
    );

    always_comb begin
        n_wp = r_wp;
        if (i_cmd.pos_clr) begin
            n_wp = '0;
        end else if (i_cmd.wr) begin
            n_wp = r_wp + 6'd1;
        end
        n_out_vld = r_out_vld;
        if (i_cmd.rd_en) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_len     <= '0;
            r_sum     <= '0;
            r_k       <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_wp      <= n_wp;
            r_out_vld <= n_out_vld;
            if (i_cmd.sum_load) begin
                r_sum <= i_rx_byte;
            end else if (i_cmd.sum_add) begin
                r_sum <= r_sum + i_rx_byte;
            end
            if (i_cmd.len_load) begin
                r_len <= i_rx_byte[5:0];
            end
            if (i_cmd.emit_start) begin
                r_k <= '0;
            end else if (i_cmd.rd_en) begin
                r_k <= r_k + 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && r_wp == slsfp_pkg::CMD_POS) begin
            r_cmd_byte <= i_rx_byte;
        end
        if (i_cmd.wr && r_wp == slsfp_pkg::EP_POS) begin
            r_ep_byte <= i_rx_byte;
        end
        if (i_cmd.emit_start) begin
            r_cnt <= r_len - slsfp_pkg::FIXED_LEN[5:0];
        end
        if (i_cmd.rd_en) begin
            r_out_idx  <= r_k;
            r_out_last <= o_sts.rd_last;
            r_out_cnt  <= r_cnt;
            r_out_cmd  <= r_cmd_byte;
            r_out_ep   <= r_ep_byte;
        end
    end

    always_comb begin
        o_sts.is_sync1  = (i_rx_byte == slsfp_pkg::SYNC_FIRST);
        o_sts.is_sync2  = (i_rx_byte == slsfp_pkg::SYNC_SECOND);
        o_sts.len_ok    = (i_rx_byte > slsfp_pkg::FIXED_LEN) && (i_rx_byte < 8'(MAX_FRAME));
        o_sts.body_more = ({1'b0, r_wp} + 7'd1) < {1'b0, r_len};
        o_sts.sum_match = (i_rx_byte == r_sum);
        o_sts.rd_last   = (r_k == r_cnt - 6'd1);
        o_sts.out_valid = r_out_vld;
    end

    assign o_out_valid         = r_out_vld;
    assign o_res.payload_byte  = rd_data;
    assign o_res.payload_index = r_out_idx;
    assign o_res.payload_count = r_out_cnt;
    assign o_res.command_byte  = r_out_cmd;
    assign o_res.endpoint_byte = r_out_ep;
    assign o_res.last_of_frame = r_out_last;

endmodule

>>> hw/rtl/sync_length_sum_frame_parser.sv
// Top level of the sync, length and additive checksum frame parser.
//
//  channel | dir | beat
//  i_rx    | in  | rx_byte: one received byte
//  o_res   | out | one payload byte with index, count, command, endpoint, last flag
//
//  One received byte is taken per cycle while parsing; the frame store takes one write a cycle.
//  A verified frame of N payload bytes then plays out one store read a cycle,
//  during which i_rx is not ready; a stalled o_res holds the run.
//  The last payload beat may wait in the output register while parsing resumes.
//  Synchronous reset puts the parser to hunting the first sync byte; no clearing pass.
module sync_length_sum_frame_parser #(
    parameter int MAX_FRAME = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    slsfp_in_if.sink    i_rx,
    slsfp_out_if.source o_res
);

    slsfp_pkg::t_cmd cmd;
    slsfp_pkg::t_sts sts;

    slsfp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_rx.valid),
        .o_in_ready  (i_rx.ready),
        .i_out_ready (o_res.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    slsfp_dp #(
        .MAX_FRAME (MAX_FRAME)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx_byte   (i_rx.rx_byte),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_res       (o_res.data)
    );

    a_no_read_while_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_rx.ready && cmd.rd_en))
        else $error("store read while accepting bytes");

    a_last_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.data.last_of_frame) |->
        ((o_res.data.payload_index + 6'd1) == o_res.data.payload_count))
        else $error("last flag on wrong index");

    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.data.payload_index < o_res.data.payload_count))
        else $error("payload index beyond count");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.ready && !o_res.data.last_of_frame) |=> o_res.valid)
        else $error("payload run broken");

endmodule
